// ===== rtl/lbs_pkg.sv =====
// Package for the log brightness stepper: widths, stage map, item record and curve constants.
`default_nettype none
package lbs_pkg;

  localparam int LVL_W  = 24;
  localparam int FRAC_W = 16;
  localparam int STEP_W = 16;
  localparam int NRM_W  = 32;
  localparam int LOGF_W = FRAC_W + 1;
  localparam int LOG_W  = 22;
  localparam int ACC_W  = 40;
  localparam int QB     = 17;
  localparam int U_W    = 15;
  localparam int UD_W   = U_W + LOG_W;
  localparam int E_W    = 22;
  localparam int P_W    = 18;
  localparam int YM_W   = LVL_W + P_W;
  localparam int IP_W   = E_W - FRAC_W;

  localparam int FULL_SCALE = 25600;
  localparam logic [27:0] RECIP25 = 28'd171798692;

  localparam int ST_IN   = 0;
  localparam int ST_LOG0 = 1;
  localparam int ST_LOGN = ST_LOG0 + LOGF_W - 1;
  localparam int ST_LOGR = ST_LOGN + 1;
  localparam int ST_NUM  = ST_LOGR + 1;
  localparam int ST_ABS  = ST_NUM + 1;
  localparam int ST_DIV0 = ST_ABS + 1;
  localparam int ST_DIVN = ST_DIV0 + QB - 1;
  localparam int ST_POS  = ST_DIVN + 1;
  localparam int ST_UD   = ST_POS + 1;
  localparam int ST_REC  = ST_UD + 1;
  localparam int ST_EXPI = ST_REC + 1;
  localparam int ST_EXP0 = ST_EXPI + 1;
  localparam int ST_EXPN = ST_EXP0 + FRAC_W - 1;
  localparam int ST_PMUL = ST_EXPN + 1;
  localparam int ST_OUT  = ST_PMUL + 1;
  localparam int N_ST    = ST_OUT + 1;

  typedef struct packed {
    logic [LVL_W-1:0]             mn;
    logic [LVL_W-1:0]             mx;
    logic [LVL_W-1:0]             lvl;
    logic signed [STEP_W-1:0]     step;
    logic                         degen;
    logic                         tzero;
    logic [2:0][4:0]              n;
    logic [2:0][NRM_W-1:0]        m;
    logic [2:0][LOGF_W-1:0]       f;
    logic [LOG_W-1:0]             d;
    logic signed [LOG_W-1:0]      num;
    logic signed [ACC_W-1:0]      a;
    logic [ACC_W-1:0]             rem;
    logic [LOG_W:0]               b;
    logic [QB-1:0]                q;
    logic                         neg;
    logic                         sat;
    logic [U_W-1:0]               u;
    logic                         hit;
    logic                         top;
    logic [UD_W-1:0]              ud;
    logic [54:0]                  rp;
    logic [E_W-1:0]               e;
    logic [NRM_W-1:0]             acc;
    logic [YM_W-1:0]              ym;
    logic [LVL_W-1:0]             res;
  } stage_t;

  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] bt;
    logic [63:0] xv;
    r  = '0;
    xv = x;
    bt = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bt > xv) bt = bt >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bt != 64'd0) begin
        if (xv >= r + bt) begin
          xv = xv - (r + bt);
          r  = (r >> 1) + bt;
        end else begin
          r = r >> 1;
        end
        bt = bt >> 2;
      end
    end
    return r;
  endfunction

  // 2^(2^-k) in Q2.30
  function automatic logic [NRM_W-1:0] exp_c(int k);
    logic [63:0] c;
    c = 64'd2 << 30;
    for (int i = 1; i <= k; i++) c = isqrt64(c << 30);
    return c[NRM_W-1:0];
  endfunction

  function automatic logic [4:0] msb_idx(logic [LVL_W-1:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 1; i < LVL_W; i++) begin
      if (v[i]) n = 5'(i);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/log_brightness_stepper.sv =====
// Log brightness stepper: pipelined step of a level along an exponential curve.
//
// Input stream s_axis carries the current level and a signed step in 1/256
// percent. Output stream m_axis returns the new level in tdata and the clamp
// flag in tuser, one result per item, in order.
// The APB port holds min_level (address 0) and max_level (address 4); write
// them only while no item is in flight.
// One item per cycle is sustained while the receiver keeps taking results; the
// 60-stage pipeline (17 log squaring stages, 17 quotient-bit stages, 16 exp
// product stages) holds up to 60 items.
// The pipeline advances as a whole whenever the output register is empty or
// being taken; while the receiver stalls with a result waiting, tready drops
// and every stage holds its item.
// Reset empties the pipeline and sets min_level to 1 and max_level to 255.
`default_nettype none
module log_brightness_stepper (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,   // current_level[23:0], step_percent[39:24]
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [23:0] m_axis_tdata_o,   // new_level[23:0]
  output      logic [0:0]  m_axis_tuser_o,   // hit_limit[0]
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [2:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output      logic [31:0] prdata_o,
  output      logic        pready_o
);

  localparam int N = lbs_pkg::N_ST;

  logic [lbs_pkg::LVL_W-1:0] min_q, max_q;
  logic [N-1:0]              v_q;
  lbs_pkg::stage_t           st_q [N];
  lbs_pkg::stage_t           st_d [N];
  logic                      en;

  assign pready_o = 1'b1;
  assign prdata_o = paddr_i[2] ? 32'(max_q) : 32'(min_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= 24'd1;
      max_q <= 24'd255;
    end else if (psel_i && penable_i && pwrite_i) begin
      if (paddr_i[2]) max_q <= pwdata_i[23:0];
      else            min_q <= pwdata_i[23:0];
    end
  end

  assign en              = !v_q[N-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = v_q[N-1];
  assign m_axis_tdata_o  = st_q[N-1].res;
  assign m_axis_tuser_o  = st_q[N-1].hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[N-2:0], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) st_q <= st_d;
  end

  for (genvar k = 0; k < N; k++) begin : g_st
    if (k == lbs_pkg::ST_IN) begin : g_in
      always_comb begin
        logic [lbs_pkg::LVL_W-1:0]        mn;
        logic signed [lbs_pkg::STEP_W-1:0] sr;
        logic [2:0][lbs_pkg::LVL_W-1:0]   vv;
        mn = (min_q == '0) ? 24'd1 : min_q;
        sr = $signed(s_axis_tdata_i[39:24]);
        st_d[k]       = '0;
        st_d[k].mn    = mn;
        st_d[k].mx    = max_q;
        st_d[k].lvl   = s_axis_tdata_i[23:0];
        st_d[k].degen = (max_q <= mn);
        if (sr > 16'sd25600)       st_d[k].step = 16'sd25600;
        else if (sr < -16'sd25600) st_d[k].step = -16'sd25600;
        else                       st_d[k].step = sr;
        vv[0] = s_axis_tdata_i[23:0];
        vv[1] = mn;
        vv[2] = max_q;
        for (int i = 0; i < 3; i++) begin
          st_d[k].n[i] = lbs_pkg::msb_idx(vv[i]);
          st_d[k].m[i] = 32'(vv[i]) << (5'd31 - lbs_pkg::msb_idx(vv[i]));
        end
      end
    end else if (k >= lbs_pkg::ST_LOG0 && k <= lbs_pkg::ST_LOGN) begin : g_log
      always_comb begin
        logic [63:0] sq;
        logic [32:0] p;
        st_d[k] = st_q[k-1];
        for (int i = 0; i < 3; i++) begin
          sq = 64'(st_q[k-1].m[i]) * 64'(st_q[k-1].m[i]);
          p  = sq[63:31];
          st_d[k].f[i] = {st_q[k-1].f[i][lbs_pkg::LOGF_W-2:0], p[32]};
          st_d[k].m[i] = p[32] ? p[32:1] : p[31:0];
        end
      end
    end else if (k == lbs_pkg::ST_LOGR) begin : g_logr
      always_comb begin
        logic [2:0][lbs_pkg::LOG_W-1:0] l;
        st_d[k] = st_q[k-1];
        for (int i = 0; i < 3; i++) begin
          l[i] = 22'({st_q[k-1].n[i], 16'b0})
               + 22'((18'(st_q[k-1].f[i]) + 18'd1) >> 1);
        end
        st_d[k].d     = l[2] - l[1];
        st_d[k].num   = $signed(l[0] - l[1]);
        st_d[k].tzero = (st_q[k-1].lvl == '0) || (l[2] == l[1]);
      end
    end else if (k == lbs_pkg::ST_NUM) begin : g_num
      always_comb begin
        st_d[k]   = st_q[k-1];
        st_d[k].a = 40'(st_q[k-1].num) * 40'sd51200 + $signed(40'(st_q[k-1].d));
        st_d[k].b = {st_q[k-1].d, 1'b0};
      end
    end else if (k == lbs_pkg::ST_ABS) begin : g_abs
      always_comb begin
        logic [lbs_pkg::ACC_W-1:0] bw;
        logic [lbs_pkg::ACC_W-1:0] av;
        bw = 40'(st_q[k-1].b);
        av = st_q[k-1].a[39] ? (40'(-st_q[k-1].a) + bw - 40'd1) : 40'(st_q[k-1].a);
        st_d[k]     = st_q[k-1];
        st_d[k].neg = st_q[k-1].a[39];
        st_d[k].rem = av;
        st_d[k].sat = av >= (bw << lbs_pkg::QB);
        st_d[k].q   = '0;
      end
    end else if (k >= lbs_pkg::ST_DIV0 && k <= lbs_pkg::ST_DIVN) begin : g_div
      localparam int BK = lbs_pkg::ST_DIVN - k;
      always_comb begin
        logic [lbs_pkg::ACC_W-1:0] bs;
        bs = 40'(st_q[k-1].b) << BK;
        st_d[k] = st_q[k-1];
        if (st_q[k-1].rem >= bs) begin
          st_d[k].rem   = st_q[k-1].rem - bs;
          st_d[k].q[BK] = 1'b1;
        end
      end
    end else if (k == lbs_pkg::ST_POS) begin : g_pos
      always_comb begin
        logic [lbs_pkg::QB-1:0] qm;
        logic signed [18:0]     t;
        logic signed [19:0]     s;
        qm = st_q[k-1].sat ? '1 : st_q[k-1].q;
        if (st_q[k-1].tzero)    t = '0;
        else if (st_q[k-1].neg) t = -$signed({2'b0, qm});
        else                    t = $signed({2'b0, qm});
        s = 20'(t) + 20'(st_q[k-1].step);
        st_d[k]     = st_q[k-1];
        st_d[k].hit = 1'b0;
        if (s < 20'sd0) begin
          st_d[k].u   = '0;
          st_d[k].hit = 1'b1;
        end else if (s > 20'sd25600) begin
          st_d[k].u   = 15'(lbs_pkg::FULL_SCALE);
          st_d[k].hit = 1'b1;
        end else begin
          st_d[k].u = s[14:0];
        end
        st_d[k].top = (st_d[k].u == 15'(lbs_pkg::FULL_SCALE));
      end
    end else if (k == lbs_pkg::ST_UD) begin : g_ud
      always_comb begin
        st_d[k]    = st_q[k-1];
        st_d[k].ud = 37'(st_q[k-1].u) * 37'(st_q[k-1].d);
      end
    end else if (k == lbs_pkg::ST_REC) begin : g_rec
      always_comb begin
        logic [37:0] x;
        x = {st_q[k-1].ud, 1'b0} + 38'(lbs_pkg::FULL_SCALE);
        st_d[k]    = st_q[k-1];
        st_d[k].rp = 55'(x[37:11]) * 55'(lbs_pkg::RECIP25);
      end
    end else if (k == lbs_pkg::ST_EXPI) begin : g_expi
      always_comb begin
        st_d[k]     = st_q[k-1];
        st_d[k].e   = st_q[k-1].rp[53:32];
        st_d[k].acc = 32'd1 << 30;
      end
    end else if (k >= lbs_pkg::ST_EXP0 && k <= lbs_pkg::ST_EXPN) begin : g_exp
      localparam int KE = k - lbs_pkg::ST_EXP0 + 1;
      localparam logic [lbs_pkg::NRM_W-1:0] CK = lbs_pkg::exp_c(KE);
      always_comb begin
        logic [63:0] pr;
        pr = 64'(st_q[k-1].acc) * 64'(CK);
        st_d[k] = st_q[k-1];
        if (st_q[k-1].e[lbs_pkg::FRAC_W-KE]) st_d[k].acc = pr[61:30];
      end
    end else if (k == lbs_pkg::ST_PMUL) begin : g_pmul
      always_comb begin
        logic [32:0]               ar;
        logic [lbs_pkg::P_W-1:0]   pv;
        ar = 33'(st_q[k-1].acc) + 33'(1 << (29 - lbs_pkg::FRAC_W));
        pv = ar[(30-lbs_pkg::FRAC_W)+lbs_pkg::P_W-1:30-lbs_pkg::FRAC_W];
        st_d[k]    = st_q[k-1];
        st_d[k].ym = 42'(st_q[k-1].mn) * 42'(pv);
      end
    end else begin : g_out
      always_comb begin
        logic [lbs_pkg::IP_W-1:0] ip;
        logic [72:0]              w;
        logic [56:0]              ys;
        ip = st_q[k-1].e[lbs_pkg::E_W-1:lbs_pkg::FRAC_W];
        w  = 73'(st_q[k-1].ym) << ip[4:0];
        ys = w[72:16];
        st_d[k] = st_q[k-1];
        if (st_q[k-1].degen) begin
          st_d[k].res = st_q[k-1].mn;
          st_d[k].hit = 1'b0;
        end else if (st_q[k-1].top || ip[5] || (ys > 57'(st_q[k-1].mx))) begin
          st_d[k].res = st_q[k-1].mx;
        end else begin
          st_d[k].res = ys[23:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== sim/lbs_checker.sv =====
// Checker for the log brightness stepper: watches the streams and the APB port, predicts, compares.
`timescale 1ns / 100ps
module lbs_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  input  wire logic [39:0] s_axis_tdata_i,
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  input  wire logic [23:0] m_axis_tdata_i,
  input  wire logic [0:0]  m_axis_tuser_i,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [2:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  input  wire logic        pready_i,
  output int               err_cnt_o,
  output int               pend_cnt_o,
  output int               item_cnt_o,
  output int               hit_cnt_o
);

  localparam logic [2:0] ADDR_MIN = 3'd0;
  localparam logic [2:0] ADDR_MAX = 3'd4;
  localparam longint SCALE = 25600;

  typedef struct packed {
    logic [lbs_pkg::LVL_W-1:0] new_level;
    logic                      hit_limit;
  } bright_t;

  bright_t                     level_q[$];
  logic [lbs_pkg::LVL_W-1:0]   cfg_min;
  logic [lbs_pkg::LVL_W-1:0]   cfg_max;

  function automatic longint unsigned curve_log2(longint unsigned v);
    int unsigned     n;
    longint unsigned m;
    longint unsigned f;
    n = 0;
    f = 0;
    while (n < 31 && (v >> (n + 1)) != 0) n++;
    m = v << (31 - n);
    for (int i = 0; i < lbs_pkg::FRAC_W + 1; i++) begin
      m = (m * m) >> 31;
      f = f << 1;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        f = f | 1;
      end
    end
    return (longint'(n) << lbs_pkg::FRAC_W) + ((f + 1) >> 1);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned bt;
    r  = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x = x - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned curve_exp2(longint unsigned fp);
    longint unsigned acc;
    longint unsigned c;
    acc = 64'd1 << 30;
    c   = 64'd2 << 30;
    for (int k = 1; k <= lbs_pkg::FRAC_W; k++) begin
      c = int_sqrt(c << 30);
      if (((fp >> (lbs_pkg::FRAC_W - k)) & 1) != 0) acc = (acc * c) >> 30;
    end
    return (acc + (64'd1 << (29 - lbs_pkg::FRAC_W))) >> (30 - lbs_pkg::FRAC_W);
  endfunction

  function automatic bright_t step_level(logic [lbs_pkg::LVL_W-1:0] lo,
                                         logic [lbs_pkg::LVL_W-1:0] hi,
                                         logic [lbs_pkg::LVL_W-1:0] lvl,
                                         logic signed [15:0] sp);
    bright_t         r;
    longint unsigned mn, mx, lmn, d, e, ip, p, y, extra;
    longint          stp, t, u, num, a, b;
    mn  = lo;
    mx  = hi;
    stp = sp;
    r   = '0;
    if (mn == 0) mn = 1;
    if (mx <= mn) begin
      r.new_level = mn[lbs_pkg::LVL_W-1:0];
      return r;
    end
    if (stp > SCALE) stp = SCALE;
    if (stp < -SCALE) stp = -SCALE;
    lmn = curve_log2(mn);
    d   = curve_log2(mx) - lmn;
    t   = 0;
    if (lvl != 0 && d != 0) begin
      num = longint'(curve_log2(lvl)) - longint'(lmn);
      a   = 2 * num * SCALE + longint'(d);
      b   = 2 * longint'(d);
      t   = a / b;
      if ((a % b) != 0 && a < 0) t--;
    end
    u = t + stp;
    if (u < 0) begin
      u = 0;
      r.hit_limit = 1'b1;
    end else if (u > SCALE) begin
      u = SCALE;
      r.hit_limit = 1'b1;
    end
    if (u == SCALE) begin
      y = mx;
    end else begin
      e  = (2 * longint'(u) * d + SCALE) / (2 * SCALE);
      ip = e >> lbs_pkg::FRAC_W;
      p  = curve_exp2(e & ((64'd1 << lbs_pkg::FRAC_W) - 1));
      y  = mn * p;
      if (ip <= lbs_pkg::FRAC_W) begin
        y = y >> (lbs_pkg::FRAC_W - ip);
      end else begin
        extra = ip - lbs_pkg::FRAC_W;
        while (extra != 0 && y <= mx) begin
          y = y << 1;
          extra--;
        end
      end
      if (y > mx) y = mx;
    end
    r.new_level = y[lbs_pkg::LVL_W-1:0];
    return r;
  endfunction

  assign pend_cnt_o = level_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    bright_t exp_r;
    if (!rst_ni) begin
      cfg_min    <= 24'd1;
      cfg_max    <= 24'd255;
      err_cnt_o  <= 0;
      item_cnt_o <= 0;
      hit_cnt_o  <= 0;
      level_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i == ADDR_MIN) cfg_min <= pwdata_i[lbs_pkg::LVL_W-1:0];
        if (paddr_i == ADDR_MAX) cfg_max <= pwdata_i[lbs_pkg::LVL_W-1:0];
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        level_q.push_back(step_level(cfg_min, cfg_max, s_axis_tdata_i[23:0],
                                     s_axis_tdata_i[39:24]));
        item_cnt_o <= item_cnt_o + 1;
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (m_axis_tuser_i[0]) hit_cnt_o <= hit_cnt_o + 1;
        if (level_q.size() == 0) begin
          if (err_cnt_o < 10) $display("unexpected result: level %0d hit %0b",
                                       m_axis_tdata_i, m_axis_tuser_i[0]);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          exp_r = level_q.pop_front();
          if (exp_r.new_level !== m_axis_tdata_i || exp_r.hit_limit !== m_axis_tuser_i[0]) begin
            if (err_cnt_o < 10)
              $display("mismatch: level exp %0d got %0d, hit exp %0b got %0b",
                       exp_r.new_level, m_axis_tdata_i, exp_r.hit_limit, m_axis_tuser_i[0]);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Testbench top for the log brightness stepper: stimulus, config phases and verdict.
`timescale 1ns / 100ps
module testbench;

  localparam int LATENCY = 60;
  localparam int WATCHDOG = 5000;
  localparam logic [2:0] ADDR_MIN = 3'd0;
  localparam logic [2:0] ADDR_MAX = 3'd4;
  localparam int N_PHASE = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // current_level[23:0], step_percent[39:24]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // new_level[23:0]
  logic [0:0]  m_axis_tuser;        // hit_limit[0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int err_cnt, pend_cnt, item_cnt, hit_cnt;
  int idle_mode = 0;
  int stall_cnt = 0;
  logic [23:0] cur_min = 24'd1;
  logic [23:0] cur_max = 24'd255;

  always #1 clk_i = ~clk_i;

  log_brightness_stepper uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_axis_tvalid), .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i(s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid), .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o(m_axis_tdata), .m_axis_tuser_o(m_axis_tuser),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_o(prdata), .pready_o(pready)
  );

  lbs_checker chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_axis_tvalid), .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i(s_axis_tdata),
    .m_axis_tvalid_i(m_axis_tvalid), .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i(m_axis_tdata), .m_axis_tuser_i(m_axis_tuser),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .err_cnt_o(err_cnt), .pend_cnt_o(pend_cnt), .item_cnt_o(item_cnt),
    .hit_cnt_o(hit_cnt)
  );

  // receiver stalls 69% in mode 2, 30% in mode 3
  always @(negedge clk_i) begin
    if (idle_mode == 2) m_axis_tready <= ($urandom_range(0, 99) >= 69);
    else if (idle_mode == 3) m_axis_tready <= ($urandom_range(0, 99) >= 30);
    else m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= WATCHDOG) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG);
      $display("** log_brightness_stepper: FAILED **");
      $finish;
    end
  end

  task automatic send_level(logic [23:0] lvl, logic [15:0] stp);
    int unsigned idle_pct;
    idle_pct = (idle_mode == 3) ? 30 : 69;
    if (idle_mode == 1 || idle_mode == 3) begin
      while ($urandom_range(0, 99) < idle_pct) begin
        s_axis_tvalid = 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {stp, lvl};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] val);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = addr;
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_curve(logic [23:0] lo, logic [23:0] hi);
    s_axis_tvalid = 1'b0;
    while (pend_cnt != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    write_reg(ADDR_MIN, {8'd0, lo});
    write_reg(ADDR_MAX, {8'd0, hi});
    cur_min = lo;
    cur_max = hi;
  endtask

  function automatic logic [23:0] pick_level();
    int unsigned lo, hi;
    lo = cur_min / 2;
    hi = (cur_max > 24'h7FFFFF) ? 24'hFFFFFF : cur_max * 2 + 1;
    if (lo > hi) hi = lo;
    case ($urandom_range(0, 9))
      0: return 24'd0;
      1: return 24'($urandom);
      2: return cur_min;
      3: return cur_max;
      default: return 24'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic logic [15:0] pick_step();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 51200) - 25600);
  endfunction

  initial begin
    logic [23:0] dir_lvl[8];
    logic [15:0] dir_stp[6];
    logic [23:0] lo, hi;
    dir_lvl = '{24'd0, 24'd1, 24'd2, 24'd128, 24'd254, 24'd255, 24'd256, 24'hFFFFFF};
    dir_stp = '{16'h0000, 16'd25600, -16'sd25600, 16'h7FFF, 16'h8000, 16'd1};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // directed: reset curve, level extremes, step extremes and saturating steps
    for (int i = 0; i < 8; i++) send_level(dir_lvl[i], dir_stp[i % 6]);
    for (int i = 0; i < 6; i++) send_level(24'd16, dir_stp[i]);
    send_level(24'd255, 16'hFFFF);
    send_level(24'd1, 16'hFFFF);
    for (int ph = 0; ph < N_PHASE; ph++) begin
      idle_mode = ph % 4;
      case (ph)
        0: begin lo = 24'd1; hi = 24'd255; end
        1: begin lo = 24'd0; hi = 24'hFFFFFF; end
        2: begin lo = 24'hFFFFFF; hi = 24'd1; end
        3: begin lo = 24'd100; hi = 24'd100; end
        4: begin lo = 24'd1; hi = 24'd2; end
        5: begin lo = 24'hFFFFFE; hi = 24'hFFFFFF; end
        default: begin
          lo = 24'($urandom_range(1, 4000));
          hi = 24'($urandom_range(lo + 1, 24'hFFFFFF));
        end
      endcase
      set_curve(lo, hi);
      for (int i = 0; i < 160; i++) send_level(pick_level(), pick_step());
    end
    s_axis_tvalid = 1'b0;
    while (pend_cnt != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    $display("covered %0d items over %0d curve settings and four idle patterns", item_cnt,
             N_PHASE + 1);
    $display("%0d results clamped at an end of the curve, %0d mismatches", hit_cnt, err_cnt);
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("** log_brightness_stepper: PASSED **");
    end else begin
      $display("** log_brightness_stepper: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lbs_pkg.sv
rtl/log_brightness_stepper.sv
sim/lbs_checker.sv
sim/testbench.sv
